[src/rpsc_pkg.sv]
// shared types, constants and pattern table of the prompt pattern risk scanner
`timescale 1ns / 1ps
package rpsc_pkg;

   localparam int WINDOW_BYTES_DEF = 15;
   localparam int PAT_BYTES        = 15;
   localparam int NUM_PATTERNS     = 19;
   localparam int CSR_INDEX_W      = 4;
   localparam int SCORE_W          = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_THR   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSPECT_THR = 4'd1;

   localparam logic [SCORE_W-1:0] BLOCK_THR_RST   = 7'd80;
   localparam logic [SCORE_W-1:0] SUSPECT_THR_RST = 7'd50;

   // categories
   localparam logic [1:0] CAT_INJ = 2'd0;
   localparam logic [1:0] CAT_JB  = 2'd1;
   localparam logic [1:0] CAT_POI = 2'd2;
   localparam logic [1:0] CAT_MAN = 2'd3;

   // verdict codes
   localparam logic [1:0] VERDICT_ALLOWED    = 2'd0;
   localparam logic [1:0] VERDICT_SUSPICIOUS = 2'd1;
   localparam logic [1:0] VERDICT_BLOCKED    = 2'd2;

   // llm reason codes
   localparam logic [1:0] REASON_NONE      = 2'd0;
   localparam logic [1:0] REASON_INJECTION = 2'd1;
   localparam logic [1:0] REASON_JAILBREAK = 2'd2;

   // scores in hundredths
   localparam logic [SCORE_W-1:0] SCORE_INJ       = 7'd95;
   localparam logic [SCORE_W-1:0] SCORE_JB        = 7'd88;
   localparam logic [SCORE_W-1:0] SCORE_LLM_CLEAN = 7'd5;
   localparam logic [SCORE_W-1:0] SCORE_POI       = 7'd75;
   localparam logic [SCORE_W-1:0] SCORE_RAG_CLEAN = 7'd2;
   localparam logic [SCORE_W-1:0] SCORE_MAN       = 7'd92;
   localparam logic [SCORE_W-1:0] SCORE_AGT_CLEAN = 7'd1;

   // string literals right-justify: last character sits in byte 0
   localparam logic [PAT_BYTES*8-1:0] PAT_TEXT [NUM_PATTERNS] = '{
      (PAT_BYTES*8)'("ignore previous"),
      (PAT_BYTES*8)'("ignore all"),
      (PAT_BYTES*8)'("system prompt"),
      (PAT_BYTES*8)'("you are now"),
      (PAT_BYTES*8)'("forget your"),
      (PAT_BYTES*8)'("disregard"),
      (PAT_BYTES*8)'("DAN"),
      (PAT_BYTES*8)'("Developer Mode"),
      (PAT_BYTES*8)'("jailbreak"),
      (PAT_BYTES*8)'("bypass"),
      (PAT_BYTES*8)'("pretend you"),
      (PAT_BYTES*8)'("[["),
      (PAT_BYTES*8)'("]]"),
      (PAT_BYTES*8)'("document says"),
      (PAT_BYTES*8)'("context:"),
      (PAT_BYTES*8)'("execute"),
      (PAT_BYTES*8)'("run command"),
      (PAT_BYTES*8)'("delete file"),
      (PAT_BYTES*8)'("rm -rf")
   };

   localparam int PAT_LEN [NUM_PATTERNS] = '{
      15, 10, 13, 11, 11, 9, 3, 14, 9, 6, 11, 2, 2, 13, 8, 7, 11, 11, 6
   };

   localparam logic [1:0] PAT_CAT [NUM_PATTERNS] = '{
      CAT_INJ, CAT_INJ, CAT_INJ, CAT_INJ, CAT_INJ, CAT_INJ,
      CAT_JB, CAT_JB, CAT_JB, CAT_JB, CAT_JB,
      CAT_POI, CAT_POI, CAT_POI, CAT_POI,
      CAT_MAN, CAT_MAN, CAT_MAN, CAT_MAN
   };

   typedef struct packed {
      logic inj;
      logic jb;
      logic poi;
      logic man;
   } seen_type;

   typedef struct packed {
      logic [1:0]         verdict;
      logic [SCORE_W-1:0] risk_pts;
      logic               model_flag;
      logic [SCORE_W-1:0] model_pts;
      logic [1:0]         model_cause;
      logic               doc_flag;
      logic [SCORE_W-1:0] doc_pts;
      logic               tool_flag;
      logic [SCORE_W-1:0] tool_pts;
   } result_type;

endpackage

[src/rpsc_scan.sv]
// byte window, parallel pattern compare and sticky category flags
`timescale 1ns / 1ps
module rpsc_scan
   import rpsc_pkg::*;
#(
   parameter int WindowBytes = WINDOW_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic [7:0] text_byte,
   input  logic       last_byte,
   output seen_type   seen_now
);

   logic [WindowBytes*8-1:0] window_ff, window_in, shifted;
   seen_type                 seen_ff, seen_in, cat_hit;
   logic                     ended_ff, ended_in;
   logic                     scanning;
   logic [NUM_PATTERNS-1:0]  pat_hit;

   // newest byte in the low byte
   assign shifted  = {window_ff[(WindowBytes-1)*8-1:0], text_byte};
   assign scanning = !ended_ff && (text_byte != 8'd0);

   for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_pat
      logic [PAT_BYTES-1:0] byte_eq;
      for (genvar k = 0; k < PAT_BYTES; k++) begin : g_byte
         if (k < PAT_LEN[p]) begin : g_cmp
            assign byte_eq[k] = shifted[8*k +: 8] == PAT_TEXT[p][8*k +: 8];
         end else begin : g_pad
            assign byte_eq[k] = 1'b1;
         end
      end
      assign pat_hit[p] = (PAT_LEN[p] <= WindowBytes) && (&byte_eq);
   end

   always_comb begin
      cat_hit = '0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         if (pat_hit[p]) begin
            case (PAT_CAT[p])
               CAT_INJ: cat_hit.inj = 1'b1;
               CAT_JB:  cat_hit.jb  = 1'b1;
               CAT_POI: cat_hit.poi = 1'b1;
               default: cat_hit.man = 1'b1;
            endcase
         end
      end
   end

   assign seen_now = scanning ? (seen_ff | cat_hit) : seen_ff;

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      ended_in  = ended_ff;
      if (go) begin
         if (last_byte) begin
            window_in = '0;
            seen_in   = '0;
            ended_in  = 1'b0;
         end else if (!ended_ff) begin
            if (text_byte == 8'd0) begin
               ended_in = 1'b1;
            end else begin
               window_in = shifted;
               seen_in   = seen_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
         ended_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

[src/rpsc_score.sv]
// guard scoring, risk maximum and verdict grading
`timescale 1ns / 1ps
module rpsc_score
   import rpsc_pkg::*;
(
   input  seen_type           seen,
   input  logic [2:0]         guard_enables,
   input  logic [SCORE_W-1:0] block_thr,
   input  logic [SCORE_W-1:0] suspect_thr,
   output result_type         result
);

   always_comb begin
      result = '0;
      if (guard_enables[0]) begin
         if (seen.inj) begin
            result.model_flag  = 1'b1;
            result.model_pts   = SCORE_INJ;
            result.model_cause = REASON_INJECTION;
         end else if (seen.jb) begin
            result.model_flag  = 1'b1;
            result.model_pts   = SCORE_JB;
            result.model_cause = REASON_JAILBREAK;
         end else begin
            result.model_pts   = SCORE_LLM_CLEAN;
            result.model_cause = REASON_NONE;
         end
      end
      if (guard_enables[1]) begin
         result.doc_flag = seen.poi;
         result.doc_pts  = seen.poi ? SCORE_POI : SCORE_RAG_CLEAN;
      end
      if (guard_enables[2]) begin
         result.tool_flag = seen.man;
         result.tool_pts  = seen.man ? SCORE_MAN : SCORE_AGT_CLEAN;
      end

      // disabled guards score zero, so a plain max is enough
      result.risk_pts = result.model_pts;
      if (result.doc_pts > result.risk_pts) result.risk_pts = result.doc_pts;
      if (result.tool_pts > result.risk_pts) result.risk_pts = result.tool_pts;

      if (result.risk_pts >= block_thr) begin
         result.verdict = VERDICT_BLOCKED;
      end else if (result.risk_pts >= suspect_thr) begin
         result.verdict = VERDICT_SUSPICIOUS;
      end else begin
         result.verdict = VERDICT_ALLOWED;
      end
   end

endmodule

[src/prompt_pattern_risk_scanner.sv]
// Prompt pattern risk scanner: takes one text byte per cycle, back to back, while req_stall is
// low. Each item goes into an input register, then is shifted into the byte window; the window
// tail is compared against all 19 patterns in parallel and the sticky category flags updated, so
// one item per cycle is sustained while nothing stalls. The result of the item that carries
// last_byte is graded into an output register and held there until taken; non-final items keep
// flowing while a result waits. A zero byte ends the text and later bytes are ignored until the
// final byte, after which all scan state is cleared. Thresholds are to be written on the csr port
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module prompt_pattern_risk_scanner
   import rpsc_pkg::*;
#(
   parameter int WindowBytes = WINDOW_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_last_byte,
   input  logic [2:0]             req_guard_enables,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_verdict,
   output logic [SCORE_W-1:0]     rsp_risk_pts,
   output logic                   rsp_model_flag,
   output logic [SCORE_W-1:0]     rsp_model_pts,
   output logic [1:0]             rsp_model_cause,
   output logic                   rsp_doc_flag,
   output logic [SCORE_W-1:0]     rsp_doc_pts,
   output logic                   rsp_tool_flag,
   output logic [SCORE_W-1:0]     rsp_tool_pts,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SCORE_W-1:0]     csr_data
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic               in_last_ff, in_last_in;
   logic [2:0]         in_en_ff, in_en_in;
   logic [SCORE_W-1:0] block_thr_ff, block_thr_in;
   logic [SCORE_W-1:0] suspect_thr_ff, suspect_thr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               go, accept;
   seen_type           seen_now;
   result_type         result;

   // a final item waits only if the output register is full and stalled
   assign go        = in_valid_ff && !(in_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !go;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   rpsc_scan #(
      .WindowBytes(WindowBytes)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .text_byte(in_byte_ff),
      .last_byte(in_last_ff),
      .seen_now (seen_now)
   );

   rpsc_score u_score (
      .seen         (seen_now),
      .guard_enables(in_en_ff),
      .block_thr    (block_thr_ff),
      .suspect_thr  (suspect_thr_ff),
      .result       (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      in_en_in    = in_en_ff;
      if (go) in_valid_in = 1'b0;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
         in_last_in  = req_last_byte;
         in_en_in    = req_guard_enables;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (go && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      block_thr_in   = block_thr_ff;
      suspect_thr_in = suspect_thr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLOCK_THR:   block_thr_in   = csr_data;
            CSR_SUSPECT_THR: suspect_thr_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         block_thr_ff   <= BLOCK_THR_RST;
         suspect_thr_ff <= SUSPECT_THR_RST;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         block_thr_ff   <= block_thr_in;
         suspect_thr_ff <= suspect_thr_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      in_en_ff   <= in_en_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_ff.verdict;
   assign rsp_risk_pts    = rsp_ff.risk_pts;
   assign rsp_model_flag  = rsp_ff.model_flag;
   assign rsp_model_pts   = rsp_ff.model_pts;
   assign rsp_model_cause = rsp_ff.model_cause;
   assign rsp_doc_flag    = rsp_ff.doc_flag;
   assign rsp_doc_pts     = rsp_ff.doc_pts;
   assign rsp_tool_flag   = rsp_ff.tool_flag;
   assign rsp_tool_pts    = rsp_ff.tool_pts;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(go && in_last_ff))
      else $error("result appeared without a final item");

   a_risk_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.risk_pts >= rsp_ff.model_pts)
                    && (rsp_ff.risk_pts >= rsp_ff.doc_pts)
                    && (rsp_ff.risk_pts >= rsp_ff.tool_pts))
      else $error("risk below a guard score");

   a_blocked_grade: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.verdict == VERDICT_BLOCKED)
         |-> rsp_ff.risk_pts >= block_thr_ff)
      else $error("blocked verdict under block threshold");

endmodule

[sim/prompt_pattern_risk_scanner_test.sv]
// self-checking testbench for the prompt pattern risk scanner
`timescale 1ns / 1ps
module prompt_pattern_risk_scanner_test;
   import rpsc_pkg::*;

   localparam int SCAN_WINDOW  = 15;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 200;

   // guard scores in hundredths
   localparam logic [SCORE_W-1:0] INJECTION_PTS = 7'd95;
   localparam logic [SCORE_W-1:0] JAILBREAK_PTS = 7'd88;
   localparam logic [SCORE_W-1:0] LLM_CLEAN_PTS = 7'd5;
   localparam logic [SCORE_W-1:0] POISON_PTS    = 7'd75;
   localparam logic [SCORE_W-1:0] RAG_CLEAN_PTS = 7'd2;
   localparam logic [SCORE_W-1:0] MANIP_PTS     = 7'd92;
   localparam logic [SCORE_W-1:0] AGENT_CLEAN_PTS = 7'd1;

   typedef logic [7:0] text_q_type [$];

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_text_byte = 8'h00;
   logic                   req_last_byte = 1'b0;
   logic [2:0]             req_guard_enables = 3'd0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_verdict;
   logic [SCORE_W-1:0]     rsp_risk_pts;
   logic                   rsp_model_flag;
   logic [SCORE_W-1:0]     rsp_model_pts;
   logic [1:0]             rsp_model_cause;
   logic                   rsp_doc_flag;
   logic [SCORE_W-1:0]     rsp_doc_pts;
   logic                   rsp_tool_flag;
   logic [SCORE_W-1:0]     rsp_tool_pts;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SCORE_W-1:0]     csr_data = '0;

   prompt_pattern_risk_scanner uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   string phrases [NUM_PATTERNS] = '{
      "ignore previous", "ignore all", "system prompt", "you are now", "forget your",
      "disregard", "DAN", "Developer Mode", "jailbreak", "bypass", "pretend you",
      "[[", "]]", "document says", "context:",
      "execute", "run command", "delete file", "rm -rf"
   };
   logic [1:0] phrase_cat [NUM_PATTERNS] = '{
      CAT_INJ, CAT_INJ, CAT_INJ, CAT_INJ, CAT_INJ, CAT_INJ,
      CAT_JB, CAT_JB, CAT_JB, CAT_JB, CAT_JB,
      CAT_POI, CAT_POI, CAT_POI, CAT_POI,
      CAT_MAN, CAT_MAN, CAT_MAN, CAT_MAN
   };

   // scanner mirror
   logic [7:0]         window [SCAN_WINDOW];
   seen_type           seen = '0;
   logic               text_done = 1'b0;
   logic [SCORE_W-1:0] block_thr = 7'd80;
   logic [SCORE_W-1:0] suspect_thr = 7'd50;

   result_type pending_verdicts [$];

   int  errors = 0;
   int  bytes_sent = 0;
   int  verdicts_checked = 0;
   int  triggered_results = 0;
   int  cycle_count = 0;
   int  input_stall_cycles = 0;
   int  hold_off_cycles = 0;
   bit  send_idle_on = 1'b0;
   bit  recv_idle_on = 1'b0;

   initial begin
      for (int i = 0; i < SCAN_WINDOW; i++) window[i] = 8'h00;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_valid && req_stall) input_stall_cycles <= input_stall_cycles + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
   endfunction

   // shift in one byte, update the category flags and grade on the final byte
   function automatic bit scan_and_grade(input logic [7:0] b, input logic last,
                                         input logic [2:0] en, output result_type r);
      int len;
      bit hit;
      logic [SCORE_W-1:0] risk;
      r = '0;
      risk = '0;
      if (!text_done) begin
         if (b == 8'h00) begin
            text_done = 1'b1;
         end else begin
            for (int i = 0; i < SCAN_WINDOW - 1; i++) window[i] = window[i+1];
            window[SCAN_WINDOW-1] = b;
            for (int p = 0; p < NUM_PATTERNS; p++) begin
               len = phrases[p].len();
               hit = 1'b1;
               for (int k = 0; k < len; k++)
                  if (window[SCAN_WINDOW-len+k] != phrases[p][k]) hit = 1'b0;
               if (hit) begin
                  case (phrase_cat[p])
                     CAT_INJ: seen.inj = 1'b1;
                     CAT_JB:  seen.jb = 1'b1;
                     CAT_POI: seen.poi = 1'b1;
                     default: seen.man = 1'b1;
                  endcase
               end
            end
         end
      end
      if (!last) return 1'b0;

      if (en[0]) begin
         if (seen.inj) begin
            r.model_flag = 1'b1;
            r.model_pts = INJECTION_PTS;
            r.model_cause = REASON_INJECTION;
         end else if (seen.jb) begin
            r.model_flag = 1'b1;
            r.model_pts = JAILBREAK_PTS;
            r.model_cause = REASON_JAILBREAK;
         end else begin
            r.model_pts = LLM_CLEAN_PTS;
            r.model_cause = REASON_NONE;
         end
         if (r.model_pts > risk) risk = r.model_pts;
      end
      if (en[1]) begin
         r.doc_flag = seen.poi;
         r.doc_pts = seen.poi ? POISON_PTS : RAG_CLEAN_PTS;
         if (r.doc_pts > risk) risk = r.doc_pts;
      end
      if (en[2]) begin
         r.tool_flag = seen.man;
         r.tool_pts = seen.man ? MANIP_PTS : AGENT_CLEAN_PTS;
         if (r.tool_pts > risk) risk = r.tool_pts;
      end
      r.risk_pts = risk;
      if (risk >= block_thr) r.verdict = VERDICT_BLOCKED;
      else if (risk >= suspect_thr) r.verdict = VERDICT_SUSPICIOUS;
      else r.verdict = VERDICT_ALLOWED;

      for (int i = 0; i < SCAN_WINDOW; i++) window[i] = 8'h00;
      seen = '0;
      text_done = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last, input logic [2:0] en);
      int gap;
      result_type r;
      gap = send_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= last;
      req_guard_enables <= en;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (scan_and_grade(b, last, en, r)) pending_verdicts.push_back(r);
   endtask

   // enables on bytes other than the final one are don't-care, so they are random
   task automatic send_text(input text_q_type text, input logic [2:0] en);
      for (int i = 0; i < text.size(); i++)
         send_byte(text[i], i == text.size() - 1,
                   (i == text.size() - 1) ? en : 3'($urandom_range(0, 7)));
   endtask

   task automatic send_phrase(input string s, input logic [2:0] en);
      text_q_type text;
      for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
      send_text(text, en);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [SCORE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BLOCK_THR) block_thr = val;
      else if (idx == CSR_SUSPECT_THR) suspect_thr = val;
   endtask

   // a stray index goes along with every update and must leave both thresholds alone
   task automatic set_thresholds(input logic [SCORE_W-1:0] blk, input logic [SCORE_W-1:0] sus,
                                 input logic [CSR_INDEX_W-1:0] stray_idx);
      wait_idle();
      write_reg(CSR_BLOCK_THR, blk);
      write_reg(stray_idx, 7'($urandom_range(0, 127)));
      write_reg(CSR_SUSPECT_THR, sus);
      csr_valid <= 1'b0;
   endtask

   task automatic build_request(output text_q_type text);
      int style;
      int p;
      int cut;
      int pos;
      text = {};
      style = int'($urandom_range(0, 9));
      if (style == 0) begin
         repeat ($urandom_range(1, 20)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(32, 126)));
         repeat ($urandom_range(1, 2)) begin
            p = int'($urandom_range(0, NUM_PATTERNS - 1));
            cut = phrases[p].len();
            // broken phrase: truncated and maybe one letter case-flipped
            if (style == 1) cut = int'($urandom_range(1, cut));
            for (int k = 0; k < cut; k++) text.push_back(phrases[p][k]);
            if (style == 1 && $urandom_range(0, 1) == 1) begin
               pos = text.size() - 1 - int'($urandom_range(0, cut - 1));
               text[pos] = text[pos] ^ 8'h20;
            end
            if ($urandom_range(0, 9) == 0) text.push_back(8'h00);
            repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(32, 126)));
         end
      end
   endtask

   task automatic run_requests(input int min_bytes, input int min_verdicts, input bit reshuffle);
      text_q_type text;
      int start_bytes;
      int produced;
      start_bytes = bytes_sent;
      produced = 0;
      while (bytes_sent - start_bytes < min_bytes || produced < min_verdicts) begin
         if (reshuffle && $urandom_range(0, 7) == 0) begin
            send_idle_on = 1'($urandom_range(0, 1));
            recv_idle_on = 1'($urandom_range(0, 1));
         end
         build_request(text);
         send_text(text, 3'($urandom_range(0, 7)));
         produced++;
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic check_result(input result_type got);
      result_type want;
      if (pending_verdicts.size() == 0) begin
         $error("result with no request outstanding");
         errors++;
         return;
      end
      want = pending_verdicts.pop_front();
      compare_field("verdict", int'(want.verdict), int'(got.verdict));
      compare_field("risk_pts", int'(want.risk_pts), int'(got.risk_pts));
      compare_field("model_flag", int'(want.model_flag), int'(got.model_flag));
      compare_field("model_pts", int'(want.model_pts), int'(got.model_pts));
      compare_field("model_cause", int'(want.model_cause), int'(got.model_cause));
      compare_field("doc_flag", int'(want.doc_flag), int'(got.doc_flag));
      compare_field("doc_pts", int'(want.doc_pts), int'(got.doc_pts));
      compare_field("tool_flag", int'(want.tool_flag), int'(got.tool_flag));
      compare_field("tool_pts", int'(want.tool_pts), int'(got.tool_pts));
      verdicts_checked++;
      if (want.model_flag || want.doc_flag || want.tool_flag)
         triggered_results++;
   endtask

   initial begin : result_checker
      int hold;
      result_type got;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_cycles > 0) begin
            hold = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            hold = recv_idle_on ? pick_gap() : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.verdict = rsp_verdict;
         got.risk_pts = rsp_risk_pts;
         got.model_flag = rsp_model_flag;
         got.model_pts = rsp_model_pts;
         got.model_cause = rsp_model_cause;
         got.doc_flag = rsp_doc_flag;
         got.doc_pts = rsp_doc_pts;
         got.tool_flag = rsp_tool_flag;
         got.tool_pts = rsp_tool_pts;
         check_result(got);
      end
   end

   // reset thresholds, injection, jailbreak and poisoning categories, injection over jailbreak, disabled guards
   task automatic test_category_scoring();
      send_phrase("DAN", 3'd1);
      send_phrase("[[", 3'd3);
      send_phrase("DANdisregard", 3'd1);
      send_phrase("]]", 3'd4);
      send_byte(8'hFF, 1'b1, 3'd0);
   endtask

   // zero byte hides what follows; a zero final byte still gives a result
   task automatic test_text_terminator();
      send_byte(8'h00, 1'b0, 3'd7);
      send_phrase("DAN", 3'd7);
      send_byte(8'h00, 1'b1, 3'd7);
   endtask

   task automatic test_threshold_extremes();
      set_thresholds(7'd0, 7'd0, 4'd15);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      run_requests(40, 4, 1'b0);
      set_thresholds(7'd127, 7'd127, 4'd2);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b1;
      run_requests(40, 4, 1'b0);
      set_thresholds(7'd100, 7'd100, 4'd10);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b0;
      run_requests(40, 4, 1'b0);
      // inverted pair: suspicious above blocked
      set_thresholds(7'd30, 7'd90, 4'd5);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      run_requests(40, 4, 1'b0);
      set_thresholds(7'd80, 7'd50, 4'd12);
   endtask

   // receiver holds off for a long stretch while single-byte requests keep coming
   task automatic test_result_backpressure();
      wait_idle();
      send_idle_on = 1'b0;
      hold_off_cycles = LONG_HOLD;
      repeat (40) send_byte(8'($urandom_range(1, 255)), 1'b1, 3'($urandom_range(0, 7)));
   endtask

   task automatic test_random_requests();
      wait_idle();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      run_requests(200, 30, 1'b1);
   endtask

   initial begin : main_sequence
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_category_scoring();
      test_text_terminator();
      test_threshold_extremes();
      test_result_backpressure();
      test_random_requests();
      wait_idle();
      $display("ran %0d text bytes and checked %0d verdicts, %0d with a guard triggered",
               bytes_sent, verdicts_checked, triggered_results);
      $display("thresholds swept from 0 to 127; input held off for %0d cycles by backpressure",
               input_stall_cycles);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/rpsc_pkg.sv
src/rpsc_scan.sv
src/rpsc_score.sv
src/prompt_pattern_risk_scanner.sv
sim/prompt_pattern_risk_scanner_test.sv
